>>> rtl/svm_pkg.sv
// Package for the sample voice mixer: sizes, action codes, descriptor and
// voice record types, and the sequencer state type. No dependencies.
package svm_pkg;

    localparam int MaxVoices   = 16;
    localparam int NumSounds   = 64;
    localparam int SampleWords = 65536;

    localparam int VoiceW = $clog2(MaxVoices);
    localparam int CountW = $clog2(MaxVoices + 1);
    localparam int SndW   = $clog2(NumSounds);
    localparam int AddrW  = $clog2(SampleWords);

    localparam logic signed [23:0] MixMax = 24'sh7FFFFF;
    localparam logic signed [23:0] MixMin = -24'sh800000;

    typedef enum logic [1:0] {
        ACT_WRITE_SAMPLE = 2'd0,
        ACT_WRITE_SOUND  = 2'd1,
        ACT_TICK         = 2'd2,
        ACT_UNUSED       = 2'd3
    } action_t;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] length;
        logic        stereo;
        logic [15:0] volume;
        logic        valid;
    } sound_t;

    typedef struct packed {
        logic            active;
        logic [SndW-1:0] snd;
        logic [15:0]     frame;
    } voice_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOICE,
        ST_LEFT,
        ST_RIGHT,
        ST_ACC,
        ST_SUM,
        ST_DONE
    } state_t;

    // Command from the sequencer to the multiply unit.
    typedef struct packed {
        logic        go;
        logic [15:0] volume;
    } mul_ctl_t;

endpackage

>>> rtl/svm_stream_if.sv
// Valid/ready channel carrying one word of a generic payload.
// Depends on nothing.
interface svm_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/svm_scale.sv
// Shared scaling unit: registered 16x16 signed-by-unsigned product, then
// Q4.12 truncation toward zero. Depends on svm_pkg.
module svm_scale (
    input  logic               clk,
    input  svm_pkg::mul_ctl_t  ctl,
    input  logic signed [15:0] sample,
    output logic signed [20:0] scaled
);
    import svm_pkg::*;

    logic signed [32:0] prod_reg;
    logic signed [32:0] prod_next;
    logic signed [32:0] adj;

    // Multiply stage.
    always_comb
    begin
        prod_next = prod_reg;
        if (ctl.go)
            prod_next = 33'(sample) * $signed({17'd0, ctl.volume});
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Truncate toward zero: bias negatives before the shift.
    always_comb
    begin
        adj = prod_reg + (prod_reg[32] ? 33'sd4095 : 33'sd0);
        scaled = adj[32:12];
    end
endmodule

>>> rtl/sample_voice_mixer_top.sv
// Top level of the sample voice mixer: sample memory, sound table, voice
// table and sequencer around one shared scaling unit. Depends on svm_pkg,
// svm_stream_if and svm_scale.
//
// Usage: one input channel carries action words (sample write, sound
// descriptor write, tick); one output channel carries one result word per
// tick. Each write sets busy_reg, which holds off the next word until it
// clears. A tick walks every voice in turn with the single sample memory
// port: an idle voice or one that retires passes ST_VOICE and ST_LEFT, a
// mono voice also ST_RIGHT and ST_ACC, and a stereo voice also ST_SUM. The
// result word is loaded into the output register in ST_DONE after the last
// voice; while a tick is walked, busy_reg keeps the input channel not ready.
// The result stays in the output register until taken; the block accepts no
// new word until then. Reset clears the sound table valid bits, all voices
// and the peak register at once; the sample memory is undefined until
// written. When the receiver stalls, the block simply waits.
module sample_voice_mixer_top (
    input logic clk,
    input logic rst_n,
    svm_stream_if.sink   in_ch,
    svm_stream_if.source out_ch
);
    import svm_pkg::*;

    logic signed [15:0] smem [SampleWords];
    sound_t  snd_mem [NumSounds];
    logic    snd_valid_reg [NumSounds];
    voice_t  voice_reg [MaxVoices];
    voice_t  voice_next;

    state_t state_reg, state_next;
    logic [VoiceW-1:0] vidx_reg;
    logic [CountW-1:0] active_reg;
    logic signed [27:0] left_reg, right_reg;
    logic signed [20:0] lsc_reg;
    logic [23:0] peak_reg;
    logic dropped_reg;
    logic busy_reg;
    logic out_valid_reg;
    logic [23:0] o_left_reg, o_right_reg, o_peak_reg;
    logic [CountW-1:0] o_active_reg;
    logic o_drop_reg;

    action_t     act;
    logic [5:0]  sid;
    logic [15:0] addr, wordin, len, vol;
    logic        st_in, trig;
    logic signed [15:0] rdata_reg;
    sound_t  cur_snd_reg;
    logic [AddrW-1:0] raddr;
    mul_ctl_t mctl;
    logic signed [20:0] scaled;
    logic accept;
    logic last;
    logic [VoiceW-1:0] free_idx;
    logic free_found;
    logic signed [23:0] sat_l, sat_r;
    logic [23:0] abs_l, abs_r, amp;

    assign act    = in_ch.data.action;
    assign sid    = in_ch.data.sound_id;
    assign addr   = in_ch.data.address;
    assign wordin = in_ch.data.sample_word;
    assign len    = in_ch.data.sound_length;
    assign st_in  = in_ch.data.stereo;
    assign vol    = in_ch.data.volume;
    assign trig   = in_ch.data.trigger;

    assign in_ch.ready = !busy_reg && !out_valid_reg;
    assign accept = in_ch.valid && in_ch.ready;
    assign last = (vidx_reg == VoiceW'(MaxVoices - 1));

    // Lowest free voice, a priority search over the active bits.
    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int v = MaxVoices - 1; v >= 0; v--)
        begin
            if (!voice_reg[v].active)
            begin
                free_found = 1'b1;
                free_idx = VoiceW'(v);
            end
        end
    end

    // Sample memory read address: left word in ST_LEFT, right word in ST_RIGHT.
    always_comb
    begin
        logic [15:0] off;
        off = cur_snd_reg.stereo ? {voice_reg[vidx_reg].frame[14:0], 1'b0}
                                 : voice_reg[vidx_reg].frame;
        if (state_reg == ST_RIGHT && cur_snd_reg.stereo)
            off = off + 16'd1;
        raddr = AddrW'(cur_snd_reg.start + off);
    end

    // Sample memory: one write port and one registered read port, usable in the same cycle.
    always_ff @(posedge clk)
    begin
        if (accept && act == ACT_WRITE_SAMPLE)
            smem[AddrW'(addr)] <= wordin;
        rdata_reg <= smem[raddr];
    end

    // Sound table payload: written on descriptor actions, read per voice.
    always_ff @(posedge clk)
    begin
        if (accept && act == ACT_WRITE_SOUND)
            snd_mem[SndW'(sid)] <= '{start: addr, length: len, stereo: st_in,
                                     volume: vol, valid: 1'b1};
        cur_snd_reg <= snd_mem[voice_reg[vidx_reg].snd];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumSounds; i++)
                snd_valid_reg[i] <= 1'b0;
        end
        else if (accept && act == ACT_WRITE_SOUND)
            snd_valid_reg[SndW'(sid)] <= 1'b1;
    end

    // The left word is scaled in ST_RIGHT, the right word in ST_ACC.
    assign mctl.go = (state_reg == ST_RIGHT) || (state_reg == ST_ACC);
    assign mctl.volume = cur_snd_reg.volume;

    svm_scale u_scale (
        .clk    (clk),
        .ctl    (mctl),
        .sample (rdata_reg),
        .scaled (scaled)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && act == ACT_TICK)
                    state_next = ST_VOICE;
            ST_VOICE:
                state_next = ST_LEFT;
            ST_LEFT:
                if (!voice_reg[vidx_reg].active ||
                    voice_reg[vidx_reg].frame >= cur_snd_reg.length)
                    state_next = last ? ST_DONE : ST_VOICE;
                else
                    state_next = ST_RIGHT;
            ST_RIGHT:
                state_next = ST_ACC;
            ST_ACC:
                if (cur_snd_reg.stereo)
                    state_next = ST_SUM;
                else
                    state_next = last ? ST_DONE : ST_VOICE;
            ST_SUM:
                state_next = last ? ST_DONE : ST_VOICE;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Voice update for the voice being visited.
    always_comb
    begin
        voice_next = voice_reg[vidx_reg];
        if (state_reg == ST_LEFT && voice_next.frame >= cur_snd_reg.length)
            voice_next.active = 1'b0;
        if ((state_reg == ST_ACC && !cur_snd_reg.stereo) || state_reg == ST_SUM)
            voice_next.frame = voice_next.frame + 16'd1;
    end

    // Saturation and peak.
    always_comb
    begin
        sat_l = (left_reg > 28'(MixMax)) ? MixMax :
                (left_reg < 28'(MixMin)) ? MixMin : left_reg[23:0];
        sat_r = (right_reg > 28'(MixMax)) ? MixMax :
                (right_reg < 28'(MixMin)) ? MixMin : right_reg[23:0];
        abs_l = sat_l[23] ? 24'(-sat_l) : sat_l;
        abs_r = sat_r[23] ? 24'(-sat_r) : sat_r;
        amp = (abs_l > abs_r) ? abs_l : abs_r;
    end

    // Sequencer registers and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vidx_reg <= '0;
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            peak_reg <= '0;
            active_reg <= '0;
            dropped_reg <= 1'b0;
            left_reg <= '0;
            right_reg <= '0;
            lsc_reg <= '0;
            for (int i = 0; i < MaxVoices; i++)
                voice_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_LEFT || state_reg == ST_ACC || state_reg == ST_SUM)
                voice_reg[vidx_reg] <= voice_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    busy_reg <= accept;
                    if (accept && act == ACT_TICK)
                    begin
                        vidx_reg <= '0;
                        active_reg <= '0;
                        left_reg <= '0;
                        right_reg <= '0;
                        dropped_reg <= 1'b0;
                        if (trig && snd_valid_reg[SndW'(sid)])
                        begin
                            if (free_found)
                                voice_reg[free_idx] <= '{active: 1'b1,
                                    snd: SndW'(sid), frame: 16'd0};
                            else
                                dropped_reg <= 1'b1;
                        end
                    end
                end
                ST_VOICE: ;
                ST_LEFT:
                    if (state_next != ST_RIGHT)
                        vidx_reg <= vidx_reg + 1'b1;
                ST_RIGHT: ;
                ST_ACC:
                    if (cur_snd_reg.stereo)
                        lsc_reg <= scaled;
                    else
                    begin
                        left_reg <= left_reg + 28'(scaled);
                        right_reg <= right_reg + 28'(scaled);
                        active_reg <= active_reg + 1'b1;
                        vidx_reg <= vidx_reg + 1'b1;
                    end
                ST_SUM:
                begin
                    left_reg <= left_reg + 28'(lsc_reg);
                    right_reg <= right_reg + 28'(scaled);
                    active_reg <= active_reg + 1'b1;
                    vidx_reg <= vidx_reg + 1'b1;
                end
                ST_DONE:
                begin
                    busy_reg <= 1'b0;
                    out_valid_reg <= 1'b1;
                    if (amp > peak_reg)
                        peak_reg <= amp;
                end
                default: ;
            endcase
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            o_left_reg <= sat_l;
            o_right_reg <= sat_r;
            o_peak_reg <= (amp > peak_reg) ? amp : peak_reg;
            o_active_reg <= active_reg;
            o_drop_reg <= dropped_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data.mix_left = o_left_reg;
    assign out_ch.data.mix_right = o_right_reg;
    assign out_ch.data.peak_level = o_peak_reg;
    assign out_ch.data.voices_active = o_active_reg;
    assign out_ch.data.trigger_dropped = o_drop_reg;
endmodule

>>> rtl/svm_checker.sv
// Port-level checker for the sample voice mixer and its bind statement.
// Depends on svm_pkg and the top level.
module svm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  voices_active,
    input logic [23:0] peak_level
);
    import svm_pkg::*;

    logic [23:0] last_peak_reg;

    // Peak of the last result word taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_peak_reg <= '0;
        else if (out_valid && out_ready)
            last_peak_reg <= peak_level;
    end

    // Input is never taken while a result waits.
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");

    // A waiting result stays until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");

    // Voice count stays within the voice pool.
    a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> voices_active <= 5'(MaxVoices)) else $error("voice count");

    // Peak never falls between results.
    a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> peak_level >= last_peak_reg) else $error("peak");
endmodule

bind sample_voice_mixer_top svm_checker u_svm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .voices_active (out_ch.data.voices_active),
    .peak_level    (out_ch.data.peak_level)
);

>>> verif/svm_tb_types_pkg.sv
// Word types carried by the mixer's input and output channels.
// Depends on svm_pkg for the action codes.
`timescale 1ns / 100ps
package svm_tb_types_pkg;
    import svm_pkg::*;

    typedef struct packed {
        action_t            action;
        logic [5:0]         sound_id;
        logic [15:0]        address;
        logic signed [15:0] sample_word;
        logic [15:0]        sound_length;
        logic               stereo;
        logic [15:0]        volume;
        logic               trigger;
    } in_word_t;

    typedef struct packed {
        logic signed [23:0] mix_left;
        logic signed [23:0] mix_right;
        logic [23:0]        peak_level;
        logic [4:0]         voices_active;
        logic               trigger_dropped;
    } out_word_t;
endpackage

>>> verif/tb_sample_voice_mixer_top.sv
// Testbench for sample_voice_mixer_top: drives action words with random gaps,
// predicts each tick's mix and checks every result word. Depends on svm_pkg,
// svm_tb_types_pkg, svm_stream_if and the mixer RTL.
`timescale 1ns / 100ps
module tb_sample_voice_mixer_top;
    import svm_pkg::*;
    import svm_tb_types_pkg::*;

    // The sample window wraps the top of memory and is written in full first,
    // so every sound kept playable reads written words only.
    localparam int WinBase = 65280;
    localparam int WinSize = 512;

    // Mixer predictor and store of expected mix words.
    class mix_scoreboard;
        logic [15:0] sample_mem [SampleWords];
        sound_t      sounds [NumSounds];
        bit          playable [NumSounds];
        voice_t      voices [MaxVoices];
        logic [23:0] peak;
        out_word_t   pending_mix [$];
        int          mismatches;

        function new();
            foreach (sounds[i])
            begin
                sounds[i] = '0;
                playable[i] = 1'b0;
            end
            foreach (voices[i])
                voices[i] = '0;
            peak = '0;
            mismatches = 0;
        endfunction

        function bit span_fits(int start, int len, bit st);
            int off;
            off = (start - WinBase + SampleWords) % SampleWords;
            return off + len * (st ? 2 : 1) <= WinSize;
        endfunction

        function bit is_playing(int id);
            foreach (voices[v])
                if (voices[v].active && voices[v].snd == id)
                    return 1'b1;
            return 1'b0;
        endfunction

        function longint scaled(int id, int offset);
            logic [15:0] a;
            longint s;
            a = sounds[id].start + offset[15:0];
            s = $signed(sample_mem[a]);
            return (s * longint'(sounds[id].volume)) / 4096;
        endfunction

        // Note an accepted input word and queue the mix it produces.
        function void note_input(in_word_t w);
            out_word_t r;
            longint    left, right, m;
            int        slot, id, f;
            logic [23:0] al, ar;
            if (w.action == ACT_WRITE_SAMPLE)
                sample_mem[w.address] = w.sample_word;
            else if (w.action == ACT_WRITE_SOUND)
            begin
                sounds[w.sound_id] = '{w.address, w.sound_length, w.stereo, w.volume, 1'b1};
                playable[w.sound_id] = span_fits(w.address, w.sound_length, w.stereo);
            end
            else if (w.action == ACT_TICK)
            begin
                r = '0;
                if (w.trigger && sounds[w.sound_id].valid)
                begin
                    slot = -1;
                    foreach (voices[v])
                        if (slot < 0 && !voices[v].active)
                            slot = v;
                    if (slot < 0)
                        r.trigger_dropped = 1'b1;
                    else
                        voices[slot] = '{1'b1, w.sound_id, 16'd0};
                end
                left = 0;
                right = 0;
                foreach (voices[v])
                begin
                    if (!voices[v].active)
                        continue;
                    id = voices[v].snd;
                    f = voices[v].frame;
                    if (f >= sounds[id].length)
                    begin
                        voices[v].active = 1'b0;
                        continue;
                    end
                    if (sounds[id].stereo)
                    begin
                        left += scaled(id, 2 * f);
                        right += scaled(id, 2 * f + 1);
                    end
                    else
                    begin
                        m = scaled(id, f);
                        left += m;
                        right += m;
                    end
                    voices[v].frame = 16'(f + 1);
                    r.voices_active++;
                end
                if (left > 8388607) left = 8388607;
                if (left < -8388608) left = -8388608;
                if (right > 8388607) right = 8388607;
                if (right < -8388608) right = -8388608;
                al = 24'(left < 0 ? -left : left);
                ar = 24'(right < 0 ? -right : right);
                if (al > peak) peak = al;
                if (ar > peak) peak = ar;
                r.mix_left = 24'(left);
                r.mix_right = 24'(right);
                r.peak_level = peak;
                pending_mix = {pending_mix, r};
            end
        endfunction

        // Compare one result word with the oldest expected mix.
        function void check_result(out_word_t got);
            out_word_t exp_w;
            if (pending_mix.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %h", got);
                return;
            end
            exp_w = pending_mix.pop_front();
            if (got.mix_left !== exp_w.mix_left || got.mix_right !== exp_w.mix_right ||
                got.peak_level !== exp_w.peak_level ||
                got.voices_active !== exp_w.voices_active ||
                got.trigger_dropped !== exp_w.trigger_dropped)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mix mismatch: exp L=%0d R=%0d pk=%0d n=%0d dr=%0b, got L=%0d R=%0d pk=%0d n=%0d dr=%0b",
                        exp_w.mix_left, exp_w.mix_right, exp_w.peak_level,
                        exp_w.voices_active, exp_w.trigger_dropped,
                        got.mix_left, got.mix_right, got.peak_level,
                        got.voices_active, got.trigger_dropped);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;
    mix_scoreboard sb;

    svm_stream_if #(.payload_t(in_word_t))  in_ch ();
    svm_stream_if #(.payload_t(out_word_t)) out_ch ();

    sample_voice_mixer_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Clock of 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver stalls at random outside the stretch with no idling.
    always @(negedge clk)
        out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 26);

    // Result words are checked at the rising edge where they are taken.
    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data);

    function automatic in_word_t mk(action_t act, int id, int addr, int smp, int len,
                                    bit st, int vol, bit trig);
        in_word_t w;
        w.action = act;
        w.sound_id = 6'(id);
        w.address = 16'(addr);
        w.sample_word = 16'(smp);
        w.sound_length = 16'(len);
        w.stereo = st;
        w.volume = 16'(vol);
        w.trigger = trig;
        return w;
    endfunction

    // Offer one word, wait until it is taken, then maybe leave a gap.
    task automatic send_word(in_word_t w);
        int gap;
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_input(w);
        if (!no_idle && $urandom_range(99) < 26)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            in_ch.data <= in_word_t'($urandom());
            gap = $urandom_range(4);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Withdraw the offered word and wait for every expected result.
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending_mix.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_volume();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r == 1) return 65535;
        return $urandom_range(65535);
    endfunction

    // Descriptor write: mostly a playable sound, sometimes an oversized one
    // that is kept away from playing voices and from triggers.
    task automatic send_random_sound();
        int id, start, off, maxlen, len;
        bit st;
        id = $urandom_range(NumSounds - 1);
        st = 1'($urandom_range(1));
        if ($urandom_range(99) < 12 && !sb.is_playing(id))
        begin
            send_word(mk(ACT_WRITE_SOUND, id, $urandom_range(65535), $urandom(),
                         $urandom_range(65535), st, pick_volume(),
                         1'($urandom_range(1))));
            return;
        end
        off = $urandom_range(WinSize - 1);
        start = (WinBase + off) % SampleWords;
        maxlen = (WinSize - off) / (st ? 2 : 1);
        if ($urandom_range(99) < 80)
            len = $urandom_range(maxlen < 30 ? maxlen : 30);
        else
            len = $urandom_range(maxlen);
        send_word(mk(ACT_WRITE_SOUND, id, start, $urandom(), len, st, pick_volume(),
                     1'($urandom_range(1))));
    endtask

    task automatic send_random_tick();
        int id;
        bit trig;
        id = $urandom_range(NumSounds - 1);
        trig = $urandom_range(99) < 70;
        if (trig && sb.sounds[id].valid && !sb.playable[id])
            trig = 1'b0;
        send_word(mk(ACT_TICK, id, $urandom_range(65535), $urandom(),
                     $urandom_range(65535), 1'($urandom_range(1)),
                     $urandom_range(65535), trig));
    endtask

    initial
    begin
        int r, addr, smp;
        sb = new();
        no_idle = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill the sample window: full-scale negative words at 0-15, positive at 16-31.
        for (int i = 0; i < WinSize; i++)
        begin
            addr = (WinBase + i) % SampleWords;
            if (addr < 16)
                smp = -32768;
            else if (addr < 32)
                smp = 32767;
            else
                smp = $urandom();
            send_word(mk(ACT_WRITE_SAMPLE, 0, addr, smp, 0, 0, 0, 0));
        end

        // Directed sounds: full-scale mono, full-scale stereo, a wrapping one,
        // a zero-length one and a tiny-gain stereo one.
        send_word(mk(ACT_WRITE_SOUND, 0, 0, 0, 16, 0, 65535, 0));
        send_word(mk(ACT_WRITE_SOUND, 1, 16, 0, 16, 1, 65535, 0));
        send_word(mk(ACT_WRITE_SOUND, 2, 65530, 0, 20, 0, 4096, 0));
        send_word(mk(ACT_WRITE_SOUND, 3, 40, 0, 0, 0, 0, 0));
        send_word(mk(ACT_WRITE_SOUND, 4, WinBase, 0, 3, 1, 1, 0));
        // Trigger of a sound never written, then the zero-length sound.
        send_word(mk(ACT_TICK, 63, 0, 0, 0, 0, 0, 1));
        send_word(mk(ACT_TICK, 3, 0, 0, 0, 0, 0, 1));
        // Fill every voice with full-scale negative samples so the mix nears
        // full scale, then one more trigger that finds no free voice.
        for (int i = 0; i < MaxVoices + 1; i++)
            send_word(mk(ACT_TICK, 0, 0, 0, 0, 0, 0, 1));
        send_word(mk(ACT_UNUSED, 2, 0, 0, 0, 0, 0, 1));
        for (int i = 0; i < MaxVoices + 2; i++)
            send_word(mk(ACT_TICK, i % 3 + 1, 0, 0, 0, 0, 0, i < 3));
        // Rewrite a playing sound with a smaller gain and a shorter length.
        send_word(mk(ACT_TICK, 1, 0, 0, 0, 0, 0, 1));
        send_word(mk(ACT_WRITE_SOUND, 1, 20, 0, 4, 1, 8192, 0));
        for (int i = 0; i < 4; i++)
            send_word(mk(ACT_TICK, 4, 0, 0, 0, 0, 0, i == 0));

        // Random part, with a stretch free of idling and one full drain.
        for (int n = 0; n < 290; n++)
        begin
            no_idle = (n >= 100 && n < 170);
            if (n == 200)
                drain();
            r = $urandom_range(99);
            if (r < 8)
                send_word(mk(ACT_WRITE_SAMPLE, $urandom_range(63), $urandom_range(65535),
                             $urandom(), $urandom_range(65535), 1'($urandom_range(1)),
                             $urandom_range(65535), 1'($urandom_range(1))));
            else if (r < 28)
                send_random_sound();
            else if (r < 30)
                send_word(mk(ACT_UNUSED, $urandom_range(63), $urandom_range(65535),
                             $urandom(), $urandom_range(65535), 1'($urandom_range(1)),
                             $urandom_range(65535), 1'($urandom_range(1))));
            else
                send_random_tick();
        end
        no_idle = 1'b0;
        @(negedge clk);
        in_ch.valid <= 1'b0;

        drain();
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_mix.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

>>> sample_voice_mixer_top.f
rtl/svm_pkg.sv
rtl/svm_stream_if.sv
rtl/svm_scale.sv
rtl/sample_voice_mixer_top.sv
rtl/svm_checker.sv
verif/svm_tb_types_pkg.sv
verif/tb_sample_voice_mixer_top.sv
